// ----- src/btncl_pkg.sv -----
// Shared types and constants for the button click and long-press qualifier.
`timescale 1ns / 1ps

package btncl_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  ticks_t;
    typedef logic [IDX_BITS-1:0]  cfg_idx_t;

    // register indexes
    localparam cfg_idx_t CFG_ACTIVE_LOW     = 2'd0;
    localparam cfg_idx_t CFG_DEBOUNCE_TICKS = 2'd1;
    localparam cfg_idx_t CFG_PRESS_TICKS    = 2'd2;
    localparam cfg_idx_t CFG_CLICK_TICKS    = 2'd3;

    // reset values
    localparam logic   RST_ACTIVE_LOW     = 1'b1;
    localparam ticks_t RST_DEBOUNCE_TICKS = 16'd60;
    localparam ticks_t RST_PRESS_TICKS    = 16'd300;
    localparam ticks_t RST_CLICK_TICKS    = 16'd400;

    typedef struct packed {
        logic   active_low;
        ticks_t debounce_ticks;
        ticks_t press_ticks;
        ticks_t click_ticks;
    } cfg_t;

    typedef struct packed {
        logic click_event;
        logic press_event;
        logic held;
    } result_t;

endpackage

// ----- src/btncl_cfg.sv -----
// Configuration register bank for the button qualifier.
`timescale 1ns / 1ps

module btncl_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                write_en,
    input  btncl_pkg::cfg_idx_t write_index,
    input  btncl_pkg::ticks_t   write_data,
    output btncl_pkg::cfg_t     cfg
);

    btncl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low     <= btncl_pkg::RST_ACTIVE_LOW;
            cfg_reg.debounce_ticks <= btncl_pkg::RST_DEBOUNCE_TICKS;
            cfg_reg.press_ticks    <= btncl_pkg::RST_PRESS_TICKS;
            cfg_reg.click_ticks    <= btncl_pkg::RST_CLICK_TICKS;
        end
        else if (write_en)
        begin
            case (write_index)
                btncl_pkg::CFG_ACTIVE_LOW:     cfg_reg.active_low     <= write_data[0];
                btncl_pkg::CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= write_data;
                btncl_pkg::CFG_PRESS_TICKS:    cfg_reg.press_ticks    <= write_data;
                btncl_pkg::CFG_CLICK_TICKS:    cfg_reg.click_ticks    <= write_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/btncl_core.sv -----
// Per-tick qualifier state and next-state logic.
`timescale 1ns / 1ps

module btncl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                level,
    input  btncl_pkg::cfg_t     cfg,
    output btncl_pkg::result_t  res
);

    btncl_pkg::time_t tick_reg, tick_next;
    logic             prev_reg, prev_next;
    logic             acc_reg, acc_next;
    btncl_pkg::time_t change_stamp_reg, change_stamp_next;
    logic             click_open_reg, click_open_next;
    btncl_pkg::time_t click_stamp_reg, click_stamp_next;
    logic             press_open_reg, press_open_next;
    logic             hold_armed_reg, hold_armed_next;
    btncl_pkg::time_t hold_start_reg, hold_start_next;
    btncl_pkg::time_t press_stamp_reg, press_stamp_next;

    function automatic logic later(input btncl_pkg::time_t now, input btncl_pkg::time_t stamp,
                                   input btncl_pkg::ticks_t limit);
        btncl_pkg::time_t diff;
        diff = now - stamp;
        return diff > {{(btncl_pkg::TIME_BITS-btncl_pkg::CFG_BITS){1'b0}}, limit};
    endfunction

    logic pressed_lvl;
    logic debounced;
    logic edge_seen;
    logic click_ok;
    logic press_ok;
    logic fire;

    always_comb
    begin
        pressed_lvl = ~cfg.active_low;
        // a change this tick zeroes the elapsed time, so it never debounces
        debounced = (level == prev_reg)
                    && later(tick_reg, change_stamp_reg, cfg.debounce_ticks);
        edge_seen = debounced && (level != acc_reg);
        click_ok  = click_open_reg || later(tick_reg, click_stamp_reg, cfg.click_ticks);
        press_ok  = press_open_reg || later(tick_reg, press_stamp_reg, cfg.press_ticks);
        acc_next  = debounced ? level : acc_reg;

        tick_next         = tick_reg + btncl_pkg::time_t'(1);
        prev_next         = level;
        change_stamp_next = (level != prev_reg) ? tick_reg : change_stamp_reg;
        click_open_next   = click_open_reg;
        click_stamp_next  = click_stamp_reg;
        press_open_next   = press_open_reg;
        hold_armed_next   = hold_armed_reg;
        hold_start_next   = hold_start_reg;
        press_stamp_next  = press_stamp_reg;

        res.click_event = 1'b0;
        fire            = 1'b0;

        if (edge_seen)
        begin
            click_open_next = click_ok;
            if (click_ok)
            begin
                // release edges use up the window but give no pulse
                res.click_event  = (acc_next == pressed_lvl);
                click_open_next  = 1'b0;
                click_stamp_next = tick_reg;
            end
        end

        if (debounced && press_ok)
        begin
            press_open_next = 1'b1;
            if (acc_next == pressed_lvl)
            begin
                if (!hold_armed_reg)
                begin
                    hold_start_next = tick_reg;
                    hold_armed_next = 1'b1;
                end
                else if (later(tick_reg, hold_start_reg, cfg.press_ticks))
                begin
                    fire             = 1'b1;
                    hold_start_next  = tick_reg;
                    press_stamp_next = tick_reg;
                    hold_armed_next  = 1'b0;
                    press_open_next  = 1'b0;
                end
            end
            else
            begin
                hold_start_next = tick_reg;
            end
        end

        res.press_event = fire;
        res.held        = (acc_next == pressed_lvl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg         <= '0;
            prev_reg         <= 1'b1;
            acc_reg          <= 1'b1;
            change_stamp_reg <= '0;
            click_open_reg   <= 1'b1;
            click_stamp_reg  <= '0;
            press_open_reg   <= 1'b1;
            hold_armed_reg   <= 1'b0;
            hold_start_reg   <= '0;
            press_stamp_reg  <= '0;
        end
        else if (accept)
        begin
            tick_reg         <= tick_next;
            prev_reg         <= prev_next;
            acc_reg          <= acc_next;
            change_stamp_reg <= change_stamp_next;
            click_open_reg   <= click_open_next;
            click_stamp_reg  <= click_stamp_next;
            press_open_reg   <= press_open_next;
            hold_armed_reg   <= hold_armed_next;
            hold_start_reg   <= hold_start_next;
            press_stamp_reg  <= press_stamp_next;
        end
    end

    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.press_event |-> res.held)
        else $error("press pulse while not held");

    a_click_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.click_event |-> res.held && (level != acc_reg))
        else $error("click pulse without press edge");

    a_press_lock: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.press_event |=> !press_open_reg && !hold_armed_reg)
        else $error("press lockout not started");

    a_click_lock: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.click_event |=> !click_open_reg)
        else $error("click lockout not started");

endmodule

// ----- src/btncl_out.sv -----
// Result register between the qualifier logic and the output channel.
`timescale 1ns / 1ps

module btncl_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  btncl_pkg::result_t res,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output btncl_pkg::result_t out_res
);

    logic               valid_reg, valid_next;
    btncl_pkg::result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |-> !load)
        else $error("pending result overwritten");

    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(res_reg))
        else $error("pending result lost");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not shown");

endmodule

// ----- src/button_click_longpress_qualifier.sv -----
// Top level of the debounced button click and long-press qualifier.
`timescale 1ns / 1ps

// One raw button sample per millisecond tick comes in as a request on the
// in_valid/in_ready channel; each request gives exactly one result request
// (click_event, press_event, held) on the out_valid/out_ready channel. The
// block takes one request per clock: the whole tick update is one pass of
// compares against the stored timestamps, and a single result register sits
// in front of the output, so in_ready is high whenever that register is empty
// or being drained this cycle. out_valid rises in the cycle after acceptance.
// The time count is TIME_BITS wide and wraps; all intervals are
// wrap-safe differences compared "greater than" the configured tick counts.
// Registers: index 0 active_low (bit 0), 1 debounce_ticks, 2 press_ticks,
// 3 click_ticks; write them only while no request is in flight. A polarity
// change alters only how the stored levels are read.
module button_click_longpress_qualifier (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                write_en,
    input  btncl_pkg::cfg_idx_t write_index,
    input  btncl_pkg::ticks_t   write_data,
    // sample channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                level,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                click_event,
    output logic                press_event,
    output logic                held
);

    btncl_pkg::cfg_t    cfg;
    btncl_pkg::result_t res;
    btncl_pkg::result_t out_res;
    logic               space;
    logic               accept;

    assign in_ready = space;
    assign accept   = in_valid && space;

    btncl_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .cfg         (cfg)
    );

    // state update happens on the same edge the sample request is taken
    btncl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .level  (level),
        .cfg    (cfg),
        .res    (res)
    );

    btncl_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign click_event = out_res.click_event;
    assign press_event = out_res.press_event;
    assign held        = out_res.held;

endmodule

// ----- bench/tb_button_click_longpress_qualifier.sv -----
// Self-checking bench for the button click and long-press qualifier.
`timescale 1ns / 1ps

// Tracks the qualifier's timestamps and lockouts for each sample request and
// queues the click/press/held flags each one should give.
class click_press_predictor;

    bit                        active_low;
    btncl_pkg::ticks_t         debounce_ticks;
    btncl_pkg::ticks_t         press_ticks;
    btncl_pkg::ticks_t         click_ticks;

    btncl_pkg::time_t          tick_now;
    btncl_pkg::time_t          change_stamp;
    btncl_pkg::time_t          click_stamp;
    btncl_pkg::time_t          hold_start;
    btncl_pkg::time_t          press_stamp;
    bit                        last_sample;
    bit                        stable_level;
    bit                        click_open;
    bit                        press_open;
    bit                        hold_armed;

    btncl_pkg::result_t        expected_flags[$];
    int                        mismatches;
    int                        results_checked;
    int                        predicted_clicks;
    int                        predicted_presses;

    function new();
        active_low     = btncl_pkg::RST_ACTIVE_LOW;
        debounce_ticks = btncl_pkg::RST_DEBOUNCE_TICKS;
        press_ticks    = btncl_pkg::RST_PRESS_TICKS;
        click_ticks    = btncl_pkg::RST_CLICK_TICKS;
        tick_now       = '0;
        change_stamp   = '0;
        click_stamp    = '0;
        hold_start     = '0;
        press_stamp    = '0;
        last_sample    = 1'b1;
        stable_level   = 1'b1;
        click_open     = 1'b1;
        press_open     = 1'b1;
        hold_armed     = 1'b0;
    endfunction

    function btncl_pkg::time_t since(btncl_pkg::time_t stamp);
        return btncl_pkg::time_t'(tick_now - stamp);
    endfunction

    function void write_reg(btncl_pkg::cfg_idx_t idx, btncl_pkg::ticks_t val);
        case (idx)
            btncl_pkg::CFG_ACTIVE_LOW:     active_low     = val[0];
            btncl_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks = val;
            btncl_pkg::CFG_PRESS_TICKS:    press_ticks    = val;
            btncl_pkg::CFG_CLICK_TICKS:    click_ticks    = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_flags.size();
    endfunction

    // one accepted sample request
    function void note_sample(bit lvl);
        btncl_pkg::result_t r;
        bit                 pressed_lvl;
        r           = '0;
        pressed_lvl = ~active_low;
        if (lvl != last_sample)
            change_stamp = tick_now;
        if (since(change_stamp) > debounce_ticks) begin
            if (lvl != stable_level) begin
                stable_level = lvl;
                if (!click_open && since(click_stamp) > click_ticks)
                    click_open = 1'b1;
                // release edges also consume the window, without a pulse
                if (click_open) begin
                    if (stable_level == pressed_lvl)
                        r.click_event = 1'b1;
                    click_open  = 1'b0;
                    click_stamp = tick_now;
                end
            end
            if (!press_open && since(press_stamp) > press_ticks)
                press_open = 1'b1;
            if (press_open) begin
                if (stable_level == pressed_lvl) begin
                    if (!hold_armed) begin
                        hold_start = tick_now;
                        hold_armed = 1'b1;
                    end
                    if (since(hold_start) > press_ticks) begin
                        hold_start    = tick_now;
                        press_stamp   = tick_now;
                        hold_armed    = 1'b0;
                        press_open    = 1'b0;
                        r.press_event = 1'b1;
                    end
                end
                else begin
                    hold_start = tick_now;
                end
            end
        end
        last_sample = lvl;
        tick_now    = tick_now + 1'b1;
        r.held      = (stable_level == pressed_lvl);
        predicted_clicks  += r.click_event;
        predicted_presses += r.press_event;
        expected_flags.push_back(r);
    endfunction

    // a long run of failures is counted in full but only the first lines shown
    task report(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR: %s", msg);
    endtask

    task check_result(btncl_pkg::result_t got);
        btncl_pkg::result_t want;
        if (expected_flags.size() == 0) begin
            report($sformatf("result %0d arrived with no sample pending", results_checked));
        end
        else begin
            want = expected_flags.pop_front();
            if (got.click_event !== want.click_event)
                report($sformatf("result %0d click_event got %b want %b",
                                 results_checked, got.click_event, want.click_event));
            if (got.press_event !== want.press_event)
                report($sformatf("result %0d press_event got %b want %b",
                                 results_checked, got.press_event, want.press_event));
            if (got.held !== want.held)
                report($sformatf("result %0d held got %b want %b",
                                 results_checked, got.held, want.held));
        end
        results_checked++;
    endtask

endclass

module tb_button_click_longpress_qualifier;

    // cycles with no request moving on either channel before giving up;
    // well above the longest sender gap plus the longest receiver stall
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 9;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                write_en    = 1'b0;
    btncl_pkg::cfg_idx_t write_index = btncl_pkg::CFG_ACTIVE_LOW;
    btncl_pkg::ticks_t   write_data  = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                level       = 1'b1;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                click_event;
    logic                press_event;
    logic                held;

    click_press_predictor pred = new();

    // quiet phases run with no gaps on either side
    bit              quiet       = 1'b0;
    int              stall_left  = 0;
    int              idle_cycles = 0;
    int              samples_sent;
    int              settings_used;
    btncl_pkg::cfg_t cur;

    button_click_longpress_qualifier DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .level       (level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .click_event (click_event),
        .press_event (press_event),
        .held        (held)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Result side back-pressure: mostly ready, short stalls now and then,
    // and the odd long one so samples back up behind the output register.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            out_ready  <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Every accepted result request is checked against the oldest prediction.
    // Values read here are the ones held before this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            pred.check_result('{click_event, press_event, held});
    end

    // Watchdog on handshake progress rather than on total run time.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        else if (r < 97)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // One sample request. valid is dropped only when a gap is taken or by
    // drain(), so it stays high across back-to-back requests.
    task send_sample(bit lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        level    <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
        pred.note_sample(lvl);
        samples_sent++;
    endtask

    // Stop sending and let every outstanding result come back, then idle on so
    // the result register is empty when the task returns.
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task write_reg(btncl_pkg::cfg_idx_t idx, btncl_pkg::ticks_t val);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= val;
        @(posedge clk);
        pred.write_reg(idx, val);
    endtask

    // Only called with the block idle.
    task apply_setting(btncl_pkg::cfg_t c);
        write_reg(btncl_pkg::CFG_ACTIVE_LOW, btncl_pkg::ticks_t'(c.active_low));
        write_reg(btncl_pkg::CFG_DEBOUNCE_TICKS, c.debounce_ticks);
        write_reg(btncl_pkg::CFG_PRESS_TICKS, c.press_ticks);
        write_reg(btncl_pkg::CFG_CLICK_TICKS, c.click_ticks);
        write_en <= 1'b0;
        cur = c;
        settings_used++;
    endtask

    // Length of the next constant-level run. Most runs outlast the debounce
    // time so edges get through and holds reach the press time; the rest are
    // glitches. Huge debounce settings only ever see short runs.
    function int pick_run();
        int span;
        if (cur.debounce_ticks > 300)
            return $urandom_range(1, 30);
        if ($urandom_range(0, 9) < 7)
        begin
            span = 2 * int'(cur.press_ticks) + 8;
            if (span > 350)
                span = 350;
            return int'(cur.debounce_ticks) + 1 + $urandom_range(1, span);
        end
        return $urandom_range(1, int'(cur.debounce_ticks) + 1);
    endfunction

    task random_phase(int n_items);
        int len;
        int sent;
        bit lvl;
        sent = 0;
        lvl  = $urandom_range(0, 1);
        while (sent < n_items)
        begin
            len = pick_run();
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                send_sample(lvl);
                sent++;
                // occasionally hold the sender off until the pipe is empty
                if ($urandom_range(0, 149) == 0)
                    drain();
            end
            // mostly an edge, sometimes the same level again
            if ($urandom_range(0, 99) < 85)
                lvl = ~lvl;
        end
        drain();
    endtask

    // Directed sequence under a tight setting (active low, debounce 0,
    // press 2, click 3): undebounced ticks, a click, a long press and its
    // repeat lockout, a release edge that restarts the click lockout, a
    // one-tick glitch, a release inside the lockout and a press after it expires.
    localparam int N_DIRECTED = 25;
    bit directed_levels [N_DIRECTED] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0
    };

    btncl_pkg::cfg_t phase_cfg   [N_PHASES];
    int              phase_items [N_PHASES];

    initial
    begin
        samples_sent  = 0;
        settings_used = 0;

        // reset settings, both polarities, all-zero and all-maximum timings,
        // and mixes of the two
        phase_cfg[0] = '{btncl_pkg::RST_ACTIVE_LOW, btncl_pkg::RST_DEBOUNCE_TICKS,
                         btncl_pkg::RST_PRESS_TICKS, btncl_pkg::RST_CLICK_TICKS};
        phase_cfg[1] = '{1'b0, 16'd0, 16'd0, 16'd0};
        phase_cfg[2] = '{1'b1, 16'd2, 16'd10, 16'd15};
        phase_cfg[3] = '{1'b0, 16'd5, 16'd30, 16'd8};
        phase_cfg[4] = '{1'b1, 16'd1, 16'd3, 16'd40};
        phase_cfg[5] = '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[6] = '{1'b1, 16'd0, 16'hFFFF, 16'd0};
        phase_cfg[7] = '{1'b0, 16'd3, 16'd0, 16'hFFFF};
        phase_cfg[8] = '{1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 25)), 16'($urandom_range(0, 30))};
        phase_items  = '{350, 100, 170, 170, 150, 60, 80, 100, 100};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting('{1'b1, 16'd0, 16'd2, 16'd3});
        foreach (directed_levels[i])
            send_sample(directed_levels[i]);
        drain();

        // stored samples carry over each polarity change on purpose
        for (int p = 0; p < N_PHASES; p++)
        begin
            quiet = (p % 3 == 2);
            apply_setting(phase_cfg[p]);
            random_phase(phase_items[p]);
        end
        quiet = 1'b0;

        // drain() has already waited for the last result and the latency
        repeat (8) @(posedge clk);

        $display("Sent %0d samples across %0d register settings; %0d results checked.",
                 samples_sent, settings_used, pred.results_checked);
        $display("Predicted %0d click pulses and %0d long-press pulses.",
                 pred.predicted_clicks, pred.predicted_presses);
        if (pred.mismatches == 0 && pred.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/btncl_pkg.sv
src/btncl_cfg.sv
src/btncl_core.sv
src/btncl_out.sv
src/button_click_longpress_qualifier.sv
bench/tb_button_click_longpress_qualifier.sv
